// ----- sv/gprb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gprb_pkg
// Shared types and constants of the gamepad register bank controller.
// ----------------------------------------------------------------------------
package gprb_pkg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_STOP   = 2'd2,
        OP_SAMPLE = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam int          CFG_IDX_W         = 3;
    localparam int          CFG_DATA_W        = 16;
    localparam logic [2:0]  CFG_LED_ENABLE    = 3'd0;
    localparam logic [2:0]  CFG_LED_GAIN      = 3'd1;
    localparam logic [2:0]  CFG_LED_WRAP      = 3'd2;
    localparam logic [2:0]  CFG_MOTOR_MIN     = 3'd3;
    localparam logic [2:0]  CFG_MOTOR_WRAP    = 3'd4;
    localparam logic [2:0]  CFG_VCC_THRESHOLD = 3'd5;

    // configuration reset values
    localparam logic        RST_LED_ENABLE    = 1'b1;
    localparam logic [8:0]  RST_LED_GAIN      = 9'd1;
    localparam logic [15:0] RST_LED_WRAP      = 16'd255;
    localparam logic [15:0] RST_MOTOR_MIN     = 16'd3090;
    localparam logic [15:0] RST_MOTOR_WRAP    = 16'd5100;
    localparam logic [11:0] RST_VCC_THRESHOLD = 12'd2400;

    // stream widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    // fixed-role part of the bank, held in flops
    localparam int          FIX_DEPTH = 10;
    localparam int          FIX_IDX_W = 4;
    localparam int          REG_MOTOR = 6;
    localparam int          REG_RED   = 7;
    localparam int          REG_GREEN = 8;
    localparam int          REG_BLUE  = 9;

    localparam logic [12:0] STICK_CAP = 13'd4096;

    // items held between input and output
    localparam int PIPE_DEPTH = 5;

endpackage

// ----- sv/gamepad_register_bank_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_register_bank_controller
// Byte register bank behind a slave bus, with LED and rumble level outputs.
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-------------------------------
//  s_axis    | s_axis_tvalid / s_axis_tready | tuser opcode, tdata bus fields
//  m_axis    | m_axis_tvalid / m_axis_tready | tdata read byte and levels
//  cfg       | i_cfg_we (no wait)            | i_cfg_idx, i_cfg_wdata
//
//  One beat in per cycle, one result out per cycle while the output is not
//  stalled; each beat passes in order through input reg, bank update,
//  multiply, clamp and quotient estimate, and quotient correction. The bank
//  update stage carries the pointer from one beat to the next.
//  Reset is synchronous: bank, pointer, valid bits and config return to
//  their defaults. A stalled output backs up stage by stage; empty stages
//  keep filling, so s_axis_tready stays high while any stage is free.
// ----------------------------------------------------------------------------
module gamepad_register_bank_controller
    import gprb_pkg::*;
#(
    parameter int BANK_DEPTH = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bus_byte[7:0], buttons[23:8], stick_x[35:24], stick_y[47:36],
    // stick_supply[59:48], zero fill [63:60]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_byte[7:0], red_level[23:8], green_level[39:24],
    // blue_level[55:40], motor_level[71:56]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int         MEM_DEPTH = BANK_DEPTH - FIX_DEPTH;
    localparam int         MEM_SLOTS = (MEM_DEPTH > 0) ? MEM_DEPTH : 1;
    localparam int         MEM_IDX_W = (MEM_SLOTS > 1) ? $clog2(MEM_SLOTS) : 1;
    localparam logic [7:0] DEPTH_B   = 8'(BANK_DEPTH);
    localparam logic [7:0] FIX_B     = 8'(FIX_DEPTH);

    // configuration
    logic        r_led_enable;
    logic [8:0]  r_led_gain;
    logic [15:0] r_led_wrap;
    logic [15:0] r_motor_min;
    logic [15:0] r_motor_wrap;
    logic [11:0] r_vcc_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_enable    <= RST_LED_ENABLE;
            r_led_gain      <= RST_LED_GAIN;
            r_led_wrap      <= RST_LED_WRAP;
            r_motor_min     <= RST_MOTOR_MIN;
            r_motor_wrap    <= RST_MOTOR_WRAP;
            r_vcc_threshold <= RST_VCC_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LED_ENABLE:    r_led_enable    <= i_cfg_wdata[0];
                CFG_LED_GAIN:      r_led_gain      <= i_cfg_wdata[8:0];
                CFG_LED_WRAP:      r_led_wrap      <= i_cfg_wdata;
                CFG_MOTOR_MIN:     r_motor_min     <= i_cfg_wdata;
                CFG_MOTOR_WRAP:    r_motor_wrap    <= i_cfg_wdata;
                CFG_VCC_THRESHOLD: r_vcc_threshold <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // stage valids and advance enables
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    logic en_a, en_b, en_c, en_d, en_e;
    logic go_b;

    assign en_e = !r_e_vld || m_axis_tready;
    assign en_d = !r_d_vld || en_e;
    assign en_c = !r_c_vld || en_d;
    assign en_b = !r_b_vld || en_c;
    assign en_a = !r_a_vld || en_b;
    assign go_b = en_b && r_a_vld;

    assign s_axis_tready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            if (en_a) r_a_vld <= s_axis_tvalid;
            if (en_b) r_b_vld <= r_a_vld;
            if (en_c) r_c_vld <= r_b_vld;
            if (en_d) r_d_vld <= r_c_vld;
            if (en_e) r_e_vld <= r_d_vld;
        end
    end

    // stage A: input register
    t_opcode     r_a_op;
    logic [7:0]  r_a_byte;
    logic [15:0] r_a_buttons;
    logic [11:0] r_a_x;
    logic [11:0] r_a_y;
    logic [11:0] r_a_supply;

    always_ff @(posedge i_clk) begin
        if (en_a && s_axis_tvalid) begin
            r_a_op      <= t_opcode'(s_axis_tuser);
            r_a_byte    <= s_axis_tdata[7:0];
            r_a_buttons <= s_axis_tdata[23:8];
            r_a_x       <= s_axis_tdata[35:24];
            r_a_y       <= s_axis_tdata[47:36];
            r_a_supply  <= s_axis_tdata[59:48];
        end
    end

    // stage B: bank update
    logic [7:0]           r_fix [FIX_DEPTH];
    logic [7:0]           n_fix [FIX_DEPTH];
    logic [7:0]           r_ptr, n_ptr;
    logic                 r_loaded, n_loaded;
    logic [7:0]           n_rd;
    logic                 mem_we;
    logic [7:0]           mem_rd_byte;
    logic                 in_range, in_fix;
    logic [FIX_IDX_W-1:0] fix_idx;
    logic                 low_supply;
    logic [12:0]          x_dbl, y_dbl, x_adj, y_adj;

    assign in_range   = r_ptr < DEPTH_B;
    assign in_fix     = r_ptr < FIX_B;
    assign fix_idx    = r_ptr[FIX_IDX_W-1:0];
    assign low_supply = r_a_supply < r_vcc_threshold;
    assign x_dbl      = {r_a_x, 1'b0};
    assign y_dbl      = {r_a_y, 1'b0};

    always_comb begin
        x_adj = {1'b0, r_a_x};
        y_adj = {1'b0, r_a_y};
        if (low_supply) begin
            x_adj = (x_dbl > STICK_CAP) ? STICK_CAP : x_dbl;
            y_adj = (y_dbl > STICK_CAP) ? STICK_CAP : y_dbl;
        end
    end

    always_comb begin
        n_fix    = r_fix;
        n_ptr    = r_ptr;
        n_loaded = r_loaded;
        n_rd     = '0;
        mem_we   = 1'b0;
        unique case (r_a_op)
            OP_WRITE: begin
                if (!r_loaded) begin
                    n_ptr    = r_a_byte;
                    n_loaded = 1'b1;
                end else if (in_range) begin
                    if (in_fix) begin
                        n_fix[fix_idx] = r_a_byte;
                    end else begin
                        mem_we = go_b;
                    end
                    n_ptr = r_ptr + 8'd1;
                end
            end
            OP_READ: begin
                if (in_range) begin
                    n_rd  = in_fix ? r_fix[fix_idx] : mem_rd_byte;
                    n_ptr = r_ptr + 8'd1;
                end
            end
            OP_STOP: begin
                n_loaded = 1'b0;
            end
            OP_SAMPLE: begin
                n_fix[0] = r_a_buttons[7:0];
                n_fix[1] = r_a_buttons[15:8];
                n_fix[2] = x_adj[7:0];
                n_fix[3] = {3'b000, x_adj[12:8]};
                n_fix[4] = y_adj[7:0];
                n_fix[5] = {3'b000, y_adj[12:8]};
            end
            default: ;
        endcase
    end

    // upper bank entries: memory with registered read, addressed ahead by
    // the pointer that the next beat will use
    logic [7:0]           mem [MEM_SLOTS];
    logic [MEM_SLOTS-1:0] r_mem_vld;
    logic [7:0]           r_mem_q;
    logic [7:0]           rd_ptr;
    logic [MEM_IDX_W-1:0] rd_idx, cur_idx;

    assign rd_ptr      = go_b ? n_ptr : r_ptr;
    assign rd_idx      = MEM_IDX_W'(rd_ptr - FIX_B);
    assign cur_idx     = MEM_IDX_W'(r_ptr - FIX_B);
    assign mem_rd_byte = r_mem_vld[cur_idx] ? r_mem_q : 8'h00;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[cur_idx] <= r_a_byte;
        r_mem_q <= mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (mem_we) begin
            r_mem_vld[cur_idx] <= 1'b1;
        end
    end

    logic [7:0] r_b_rd, r_b_motor, r_b_red, r_b_green, r_b_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FIX_DEPTH; i++) r_fix[i] <= 8'h00;
            r_ptr    <= 8'h00;
            r_loaded <= 1'b0;
        end else if (go_b) begin
            r_fix    <= n_fix;
            r_ptr    <= n_ptr;
            r_loaded <= n_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go_b) begin
            r_b_rd    <= n_rd;
            r_b_motor <= n_fix[REG_MOTOR];
            r_b_red   <= n_fix[REG_RED];
            r_b_green <= n_fix[REG_GREEN];
            r_b_blue  <= n_fix[REG_BLUE];
        end
    end

    // stage C: products
    logic [7:0]  r_c_rd;
    logic [16:0] r_c_red_p, r_c_green_p, r_c_blue_p;
    logic [23:0] r_c_mot_p;
    logic        r_c_mot_zero, r_c_mot_rev;
    logic [15:0] motor_span;

    assign motor_span = r_motor_wrap - r_motor_min;

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_vld) begin
            r_c_rd       <= r_b_rd;
            r_c_red_p    <= 17'(r_b_red) * 17'(r_led_gain);
            r_c_green_p  <= 17'(r_b_green) * 17'(r_led_gain);
            r_c_blue_p   <= 17'(r_b_blue) * 17'(r_led_gain);
            r_c_mot_p    <= 24'(r_b_motor) * 24'(motor_span);
            r_c_mot_zero <= (r_b_motor == 8'h00);
            r_c_mot_rev  <= (r_motor_wrap < r_motor_min);
        end
    end

    // stage D: LED clamp, quotient estimate for the divide by 255
    function automatic logic [15:0] led_level(input logic [16:0] prod,
                                              input logic [15:0] wrap,
                                              input logic        enable);
        logic [15:0] clamped;
        clamped = (prod > {1'b0, wrap}) ? wrap : prod[15:0];
        return enable ? (wrap - clamped) : 16'h0000;
    endfunction

    logic [16:0] t_sum;
    logic [25:0] rem_full;
    logic [7:0]  r_d_rd;
    logic [15:0] r_d_red, r_d_green, r_d_blue;
    logic [15:0] r_d_t;
    logic [9:0]  r_d_rem;
    logic        r_d_mot_zero, r_d_mot_rev;

    // p/256 + p/65536 falls short of p/255 by less than three
    assign t_sum    = 17'(r_c_mot_p[23:8]) + 17'(r_c_mot_p[23:16]);
    assign rem_full = 26'(r_c_mot_p) + 26'(t_sum[15:0]) - 26'({t_sum[15:0], 8'h00});

    always_ff @(posedge i_clk) begin
        if (en_d && r_c_vld) begin
            r_d_rd       <= r_c_rd;
            r_d_red      <= led_level(r_c_red_p, r_led_wrap, r_led_enable);
            r_d_green    <= led_level(r_c_green_p, r_led_wrap, r_led_enable);
            r_d_blue     <= led_level(r_c_blue_p, r_led_wrap, r_led_enable);
            r_d_t        <= t_sum[15:0];
            r_d_rem      <= rem_full[9:0];
            r_d_mot_zero <= r_c_mot_zero;
            r_d_mot_rev  <= r_c_mot_rev;
        end
    end

    // stage E: quotient correction, motor level, output register
    logic [15:0] quot;
    logic [15:0] motor_lvl;
    logic [7:0]  r_e_rd;
    logic [15:0] r_e_red, r_e_green, r_e_blue, r_e_motor;

    always_comb begin
        if (r_d_rem >= 10'd510) begin
            quot = r_d_t + 16'd2;
        end else if (r_d_rem >= 10'd255) begin
            quot = r_d_t + 16'd1;
        end else begin
            quot = r_d_t;
        end
        if (r_d_mot_zero) begin
            motor_lvl = 16'h0000;
        end else if (r_d_mot_rev) begin
            motor_lvl = r_motor_min;
        end else begin
            motor_lvl = quot + r_motor_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e && r_d_vld) begin
            r_e_rd    <= r_d_rd;
            r_e_red   <= r_d_red;
            r_e_green <= r_d_green;
            r_e_blue  <= r_d_blue;
            r_e_motor <= motor_lvl;
        end
    end

    assign m_axis_tvalid = r_e_vld;
    assign m_axis_tdata  = {r_e_motor, r_e_blue, r_e_green, r_e_red, r_e_rd};

endmodule

// ----- sv/gprb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gprb_checker
// Port-level checks of the gamepad register bank controller.
// ----------------------------------------------------------------------------
module gprb_checker
    import gprb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [2:0] r_inflight;
    logic       s_beat, m_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_beat = m_axis_tvalid && m_axis_tready;

    // count beats taken in and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 3'd0;
        end else begin
            r_inflight <= r_inflight + 3'(s_beat) - 3'(m_beat);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != 3'd0)
        else $error("result without a pending beat");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'(PIPE_DEPTH))
        else $error("more beats in flight than stages");

endmodule

bind gamepad_register_bank_controller gprb_checker u_gprb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
